/* src/tdt_pkg.sv */
// Shared constants and types for the table driven DFA tokenizer.
package tdt_pkg;

  localparam int unsigned TRANS_WORDS = 4096;
  localparam int unsigned EOF_WORDS   = 1024;
  localparam int unsigned CLASS_WORDS = 256;

  localparam int TRANS_AW = $clog2(TRANS_WORDS);
  localparam int EOF_AW   = $clog2(EOF_WORDS);
  localparam int CLASS_AW = $clog2(CLASS_WORDS);

  localparam int STATE_W = 16;
  localparam int ID_W    = 12;

  // func codes
  localparam logic [2:0] FUNC_BYTE   = 3'd0;
  localparam logic [2:0] FUNC_EOS    = 3'd1;
  localparam logic [2:0] FUNC_WCLASS = 3'd2;
  localparam logic [2:0] FUNC_WTRANS = 3'd3;
  localparam logic [2:0] FUNC_WEOF   = 3'd4;
  localparam logic [2:0] FUNC_SET    = 3'd5;

  // action kind in bits 31..29
  localparam logic [2:0] KIND_ACCEPT = 3'b100;

  // where the live DFA state comes from
  localparam logic [1:0] SRC_SET   = 2'd0;
  localparam logic [1:0] SRC_TRANS = 2'd1;
  localparam logic [1:0] SRC_EOF   = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] byte_offset;
    logic [11:0] table_index;
    logic [31:0] table_word;
  } item_t;

endpackage

/* src/table_driven_dfa_tokenizer_unit.sv */
// Top level of the table driven DFA tokenizer: pipeline control and result register.
//
// Programmable DFA tokenizer. Every input beat either loads one table entry
// (class, transition or end-of-stream table), sets the DFA state, scans one
// byte, or marks end of stream; beats with a spare func code do nothing.
// The block takes one beat per clock while in_stall is low. A beat
// first reads the byte's class from the 256-entry class table, then
// adds the class to the live state and reads the transition (or
// end-of-stream) table, and last decides ACCEPT and loads the result
// register. What limits the rate is the state loop: the
// transition table's registered read data feeds the adder that forms the
// next transition address. Only ACCEPT actions (top bits 100) give a result
// beat, carrying token id bits 27..16 and the beat's byte offset; all other
// beats give none. Addresses past a table read as a CONTINUE to state 0.
// Table contents are undefined until written and there is no clearing pass.
// Input stall rises only when all stages are full and the held result waits.
module table_driven_dfa_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_byte_value,
  input  logic [31:0] in_byte_offset,
  input  logic [11:0] in_table_index,
  input  logic [31:0] in_table_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_token_id,
  output logic [31:0] out_token_end
);

  tdt_pkg::item_t in_item;
  tdt_pkg::item_t s1_item_r;
  logic           s1_v_r, s1_v_nxt;
  logic           s2_v_r, s2_v_nxt;
  logic [2:0]     s2_func_r;
  logic [31:0]    s2_off_r;
  logic           out_v_r, out_v_nxt;
  logic [11:0]    out_id_r;
  logic [31:0]    out_end_r;

  logic [15:0]    cls;
  logic [31:0]    action;
  logic           in_beat, s1_go, s2_free, s2_accept, out_ready;

  assign in_item.func        = in_func;
  assign in_item.byte_offset = in_byte_offset;
  assign in_item.table_index = in_table_index;
  assign in_item.table_word  = in_table_word;

  // stage 0: class lookup and class writes at the input beat
  tdt_class_stage u_class (
    .clk        (clk),
    .beat_en    (in_beat),
    .item       (in_item),
    .byte_value (in_byte_value),
    .cls        (cls)
  );

  // stage 1: transition/eof access and state update
  tdt_action_stage u_action (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .item   (s1_item_r),
    .cls    (cls),
    .action (action)
  );

  // stage 2 gives a result only for byte / eos beats whose action accepts
  assign s2_accept = s2_v_r &&
                     ((s2_func_r == tdt_pkg::FUNC_BYTE) || (s2_func_r == tdt_pkg::FUNC_EOS)) &&
                     (action[31:29] == tdt_pkg::KIND_ACCEPT);

  assign out_ready = !out_v_r || !out_stall;
  // stage 2 drains freely unless it carries a token that cannot be stored
  assign s2_free   = !s2_v_r || !s2_accept || out_ready;
  assign s1_go     = s1_v_r && s2_free;
  assign in_stall  = s1_v_r && !s2_free;
  assign in_beat   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt  = in_beat ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt  = s2_free ? s1_go : s2_v_r;
    out_v_nxt = out_v_r;
    if (s2_accept && s2_free) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      s2_func_r <= s1_item_r.func;
      s2_off_r  <= s1_item_r.byte_offset;
    end
    if (s2_accept && s2_free) begin
      out_id_r  <= action[27:16];
      out_end_r <= s2_off_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_token_id  = out_id_r;
  assign out_token_end = out_end_r;

`ifndef SYNTHESIS
  // input only backs up when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with a free stage");

  // an advancing stage 1 beat always lands in stage 2
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> s2_v_r)
    else $error("stage 1 beat lost");

  // a new result only comes out of an occupied stage 2
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !$past(out_v_r)) |-> $past(s2_v_r))
    else $error("result without stage 2 beat");
`endif

endmodule

/* src/tdt_class_stage.sv */
// Byte equivalence-class table with registered read.
module tdt_class_stage (
  input  logic                 clk,
  input  logic                 beat_en,
  input  tdt_pkg::item_t       item,
  input  logic [7:0]           byte_value,
  output logic [15:0]          cls
);

  logic [15:0] class_mem [tdt_pkg::CLASS_WORDS];
  logic [15:0] cls_r;
  logic [31:0] idx_ext;
  logic        wr_en;

  assign idx_ext = {20'd0, item.table_index};
  assign wr_en   = beat_en && (item.func == tdt_pkg::FUNC_WCLASS) &&
                   (idx_ext < tdt_pkg::CLASS_WORDS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      class_mem[idx_ext[tdt_pkg::CLASS_AW-1:0]] <= item.table_word[15:0];
    end
    // read is only used by byte beats; harmless for others
    if (beat_en) begin
      cls_r <= class_mem[byte_value];
    end
  end

  assign cls = cls_r;

endmodule

/* src/tdt_action_stage.sv */
// Transition and end-of-stream tables, live DFA state and action select.
module tdt_action_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  tdt_pkg::item_t       item,
  input  logic [15:0]          cls,
  output logic [31:0]          action
);

  logic [31:0] trans_mem [tdt_pkg::TRANS_WORDS];
  logic [31:0] eof_mem   [tdt_pkg::EOF_WORDS];

  logic [31:0] trans_rd_r;
  logic [31:0] eof_rd_r;
  logic        oob_r, oob_nxt;
  logic [1:0]  src_r, src_nxt;
  logic [15:0] load_state_r, load_state_nxt;

  logic [15:0] cur_state;
  logic [16:0] byte_addr;
  logic [31:0] taddr_ext, eaddr_ext, idx_ext;
  logic        is_byte, is_eos, t_oob, e_oob;

  // action of the last byte or end-of-stream beat; out of range reads zero
  always_comb begin
    if (oob_r) begin
      action = '0;
    end else if (src_r == tdt_pkg::SRC_EOF) begin
      action = eof_rd_r;
    end else begin
      action = trans_rd_r;
    end
  end

  assign cur_state = (src_r == tdt_pkg::SRC_SET) ? load_state_r : action[15:0];

  assign byte_addr = {1'b0, cur_state} + {1'b0, cls};
  assign taddr_ext = {17'd0, byte_addr[16:2]};
  assign eaddr_ext = {18'd0, cur_state[15:2]};
  assign idx_ext   = {20'd0, item.table_index};
  assign t_oob     = taddr_ext >= tdt_pkg::TRANS_WORDS;
  assign e_oob     = eaddr_ext >= tdt_pkg::EOF_WORDS;
  assign is_byte   = go && (item.func == tdt_pkg::FUNC_BYTE);
  assign is_eos    = go && (item.func == tdt_pkg::FUNC_EOS);

  always_comb begin
    src_nxt        = src_r;
    oob_nxt        = oob_r;
    load_state_nxt = load_state_r;
    if (is_byte) begin
      src_nxt = tdt_pkg::SRC_TRANS;
      oob_nxt = t_oob;
    end else if (is_eos) begin
      src_nxt = tdt_pkg::SRC_EOF;
      oob_nxt = e_oob;
    end else if (go && (item.func == tdt_pkg::FUNC_SET)) begin
      src_nxt        = tdt_pkg::SRC_SET;
      load_state_nxt = item.table_word[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r        <= tdt_pkg::SRC_SET;
      load_state_r <= '0;
      oob_r        <= 1'b0;
    end else begin
      src_r        <= src_nxt;
      load_state_r <= load_state_nxt;
      oob_r        <= oob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (item.func == tdt_pkg::FUNC_WTRANS) && (idx_ext < tdt_pkg::TRANS_WORDS)) begin
      trans_mem[idx_ext[tdt_pkg::TRANS_AW-1:0]] <= item.table_word;
    end
    if (is_byte && !t_oob) begin
      trans_rd_r <= trans_mem[taddr_ext[tdt_pkg::TRANS_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (go && (item.func == tdt_pkg::FUNC_WEOF) && (idx_ext < tdt_pkg::EOF_WORDS)) begin
      eof_mem[idx_ext[tdt_pkg::EOF_AW-1:0]] <= item.table_word;
    end
    if (is_eos && !e_oob) begin
      eof_rd_r <= eof_mem[eaddr_ext[tdt_pkg::EOF_AW-1:0]];
    end
  end

endmodule

/* dv/tb_table_driven_dfa_tokenizer_unit.sv */
// Self-checking testbench for the table driven DFA tokenizer: directed and random beats.
module tb_table_driven_dfa_tokenizer_unit;

  // Spare func codes; the block must drop these beats without a result.
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  // Plain CONTINUE kind; every kind other than ACCEPT behaves the same.
  localparam logic [2:0] KIND_CONTINUE = 3'b000;

  localparam int RANDOM_BEATS   = 850;
  localparam int DRAIN_CYCLES   = 16;   // extra wait for stray results after the queue empties
  localparam int WATCHDOG_LIMIT = 4000; // idle cycles before the run is called hung

  typedef struct {
    logic [11:0] id;
    logic [31:0] pos;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [7:0]  in_byte_value;
  logic [31:0] in_byte_offset;
  logic [11:0] in_table_index;
  logic [31:0] in_table_word;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_token_id;
  logic [31:0] out_token_end;

  // Shadow copy of the automaton: live state plus the three tables. The
  // *_ok flags record which entries were loaded, so that the stimulus never
  // scans through an entry whose contents are still undefined.
  logic [15:0] dfa_state;
  logic [15:0] class_mem [tdt_pkg::CLASS_WORDS];
  logic [31:0] trans_mem [tdt_pkg::TRANS_WORDS];
  logic [31:0] eof_mem   [tdt_pkg::EOF_WORDS];
  bit          class_ok  [tdt_pkg::CLASS_WORDS];
  bit          trans_ok  [tdt_pkg::TRANS_WORDS];
  bit          eof_ok    [tdt_pkg::EOF_WORDS];

  token_t      token_q [$];   // tokens predicted but not yet seen on the out side
  int          mismatches;
  int unsigned beats_sent;    // accepted beats that the block acts on
  bit          quiet;         // when set neither side idles or stalls

  table_driven_dfa_tokenizer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_byte_value  (in_byte_value),
    .in_byte_offset (in_byte_offset),
    .in_table_index (in_table_index),
    .in_table_word  (in_table_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_id   (out_token_id),
    .out_token_end  (out_token_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------

  // Idle length: mostly none, sometimes a few cycles, rarely a long hole.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // States are byte offsets into the transition table. Most land on a small
  // grid so entries get revisited; a few sit near the top of the range.
  function automatic logic [15:0] pick_state();
    case ($urandom_range(0, 15))
      0: return 16'($urandom);
      1: return 16'hffff - 16'($urandom_range(0, 7));
      2: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 31) * 32);
    endcase
  endfunction

  function automatic logic [15:0] pick_class();
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 31));
  endfunction

  // Action word: kind in 31..29, token id in 27..16, next state in 15..0.
  // Odd kinds (001, 010, ...) must act exactly like CONTINUE.
  function automatic logic [31:0] rand_action();
    logic [2:0] kind;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      kind = tdt_pkg::KIND_ACCEPT;
    end else if (r < 7) begin
      kind = KIND_CONTINUE;
    end else begin
      kind = 3'($urandom);
    end
    return {kind, 1'($urandom), 12'($urandom), pick_state()};
  endfunction

  // Word address of the transition a byte would take from the current state.
  function automatic int unsigned trans_word_addr(logic [7:0] b);
    return (32'(dfa_state) + 32'(class_mem[b])) >> 2;
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: applies one accepted beat to the shadow automaton and queues
  // the token it produces, if any.
  // ---------------------------------------------------------------------
  function automatic void tokenizer_predict(logic [2:0] f, logic [7:0] b, logic [31:0] off,
                                            logic [11:0] idx, logic [31:0] w);
    int unsigned addr;
    logic [31:0] action;
    bit          scans;
    token_t      tok;
    scans  = 1'b0;
    action = '0;
    case (f)
      tdt_pkg::FUNC_BYTE: begin
        scans = 1'b1;
        addr  = trans_word_addr(b);
        if (addr < tdt_pkg::TRANS_WORDS) action = trans_mem[addr];
      end
      tdt_pkg::FUNC_EOS: begin
        scans = 1'b1;
        addr  = 32'(dfa_state) >> 2;
        if (addr < tdt_pkg::EOF_WORDS) action = eof_mem[addr];
      end
      tdt_pkg::FUNC_WCLASS: begin
        if (idx < tdt_pkg::CLASS_WORDS) begin
          class_mem[idx] = w[15:0];
          class_ok[idx]  = 1'b1;
        end
      end
      tdt_pkg::FUNC_WTRANS: begin
        if (idx < tdt_pkg::TRANS_WORDS) begin
          trans_mem[idx] = w;
          trans_ok[idx]  = 1'b1;
        end
      end
      tdt_pkg::FUNC_WEOF: begin
        if (idx < tdt_pkg::EOF_WORDS) begin
          eof_mem[idx] = w;
          eof_ok[idx]  = 1'b1;
        end
      end
      tdt_pkg::FUNC_SET: dfa_state = w[15:0];
      default: ;
    endcase
    // A read past the end of a table yields zero: CONTINUE to state 0.
    if (scans) begin
      dfa_state = action[15:0];
      if (action[31:29] == tdt_pkg::KIND_ACCEPT) begin
        tok.id  = action[27:16];
        tok.pos = off;
        token_q.push_back(tok);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input side. Called at a falling edge, returns at a falling edge with
  // in_valid low. Inputs change only on falling edges so the block sees
  // stable values at every rising edge.
  // ---------------------------------------------------------------------
  task automatic send_beat(input logic [2:0] f, input logic [7:0] b, input logic [31:0] off,
                           input logic [11:0] idx, input logic [31:0] w);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
    in_valid       = 1'b1;
    in_func        = f;
    in_byte_value  = b;
    in_byte_offset = off;
    in_table_index = idx;
    in_table_word  = w;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    tokenizer_predict(f, b, off, idx, w);
    if (f <= tdt_pkg::FUNC_SET) beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Table load; byte and offset fields carry junk the block must ignore.
  task automatic write_entry(input logic [2:0] f, input logic [11:0] idx, input logic [31:0] w);
    send_beat(f, 8'($urandom), 32'($urandom), idx, w);
  endtask

  task automatic jump_to_state(input logic [15:0] s);
    send_beat(tdt_pkg::FUNC_SET, 8'($urandom), 32'($urandom), 12'($urandom),
              {16'($urandom), s});
  endtask

  // Scan one byte. Any class or transition entry the scan would touch and
  // that is still unloaded gets a random value first.
  task automatic scan_byte(input logic [7:0] b, input logic [31:0] off);
    int unsigned addr;
    if (!class_ok[b]) write_entry(tdt_pkg::FUNC_WCLASS, 12'(b), {16'($urandom), pick_class()});
    addr = trans_word_addr(b);
    if (addr < tdt_pkg::TRANS_WORDS && !trans_ok[addr])
      write_entry(tdt_pkg::FUNC_WTRANS, 12'(addr), rand_action());
    send_beat(tdt_pkg::FUNC_BYTE, b, off, 12'($urandom), 32'($urandom));
  endtask

  task automatic end_stream(input logic [31:0] off);
    int unsigned addr;
    addr = 32'(dfa_state) >> 2;
    if (addr < tdt_pkg::EOF_WORDS && !eof_ok[addr])
      write_entry(tdt_pkg::FUNC_WEOF, 12'(addr), rand_action());
    send_beat(tdt_pkg::FUNC_EOS, 8'($urandom), off, 12'($urandom), 32'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall runs, forced low while quiet is set.
  // ---------------------------------------------------------------------
  initial begin : result_stall
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
        hold      = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        hold      = $urandom_range(0, 12);
      end else begin
        out_stall = 1'b1;
        hold      = pick_gap();
      end
    end
  end

  // Result checker: every accepted result beat must match the oldest token.
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected token: id=%h end=%h", $realtime, out_token_id,
                   out_token_end);
      end else begin
        want = token_q.pop_front();
        if (out_token_id !== want.id || out_token_end !== want.pos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] token mismatch: expected id=%h end=%h, got id=%h end=%h",
                     $realtime, want.id, want.pos, out_token_id, out_token_end);
        end
      end
    end
  end

  // Watchdog: any long run of cycles with no beat on either side is a hang.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Straight out of reset the state is 0, so end of stream reads eof entry 0.
  // Largest token id and largest offset.
  task automatic test_eos_from_reset();
    write_entry(tdt_pkg::FUNC_WEOF, 12'd0, {tdt_pkg::KIND_ACCEPT, 1'b1, 12'hfff, 16'h0000});
    end_stream(32'hffff_ffff);
  endtask

  // Walk all eight action kinds through the byte path; only ACCEPT gives a
  // token. The class word carries junk in its upper half, which is dropped.
  // ACCEPT lands on id 0 and offset 0.
  task automatic test_action_kinds();
    logic [2:0] kind;
    write_entry(tdt_pkg::FUNC_WCLASS, 12'h000, 32'hffff_0000);
    for (int k = 0; k < 8; k++) begin
      kind = 3'(k);
      write_entry(tdt_pkg::FUNC_WTRANS, 12'h000,
                  {kind, 1'b1,
                   (kind == tdt_pkg::KIND_ACCEPT) ? 12'h000 : 12'($urandom),
                   16'h0000});
      scan_byte(8'h00, 32'(k) - 32'd4);
    end
  endtask

  // Reads past the end of the transition and eof tables fall back to
  // CONTINUE to state 0; the last in-range entry of each table still works.
  task automatic test_table_edges();
    jump_to_state(16'hffff);
    write_entry(tdt_pkg::FUNC_WCLASS, 12'h0ff, 32'h1234_ffff);
    scan_byte(8'hff, 32'h0000_0001);           // (ffff + ffff) / 4 is past the table
    jump_to_state(16'hfffc);
    end_stream(32'h0000_0002);                 // eof word 3fff is past the table
    jump_to_state(16'h0ffc);
    write_entry(tdt_pkg::FUNC_WEOF, 12'd1023,
                {tdt_pkg::KIND_ACCEPT, 1'b0, 12'h5a5, 16'h3ffc});
    end_stream(32'h8000_0000);
    write_entry(tdt_pkg::FUNC_WTRANS, 12'hfff,
                {tdt_pkg::KIND_ACCEPT, 1'b1, 12'ha5a, 16'h0000});
    scan_byte(8'h00, 32'h7fff_ffff);           // state 3ffc + class 0 hits word fff
  endtask

  // Out-of-range writes and spare func codes must leave everything alone.
  // A block that wraps the eof index would overwrite entry 0 here.
  task automatic test_ignored_beats();
    write_entry(tdt_pkg::FUNC_WEOF, 12'd0, {tdt_pkg::KIND_ACCEPT, 1'b0, 12'h123, 16'h0000});
    write_entry(tdt_pkg::FUNC_WEOF, 12'd1024, {tdt_pkg::KIND_ACCEPT, 1'b1, 12'habc, 16'h0040});
    write_entry(tdt_pkg::FUNC_WCLASS, 12'hfff, 32'h0000_0004);
    send_beat(FUNC_SPARE6, 8'($urandom), 32'($urandom), 12'($urandom), 32'($urandom));
    send_beat(FUNC_SPARE7, 8'($urandom), 32'($urandom), 12'($urandom), 32'($urandom));
    jump_to_state(16'h0000);
    end_stream(32'h0000_0100);
  endtask

  // Mostly well-formed streams over a small alphabet so tables get reused,
  // mixed with stray writes anywhere in the index space, state jumps and
  // spare codes. Roughly one stream in six runs with no idling at all.
  task automatic test_random_streams();
    logic [7:0]  alphabet [16];
    logic [7:0]  b;
    logic [31:0] off;
    int unsigned first;
    int          len;
    for (int i = 0; i < 16; i++) alphabet[i] = 8'($urandom);
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 11))
        0: write_entry(tdt_pkg::FUNC_WCLASS, 12'($urandom), 32'($urandom));
        1: write_entry(tdt_pkg::FUNC_WTRANS, 12'($urandom), rand_action());
        2: write_entry(tdt_pkg::FUNC_WEOF, 12'($urandom), rand_action());
        3: write_entry(tdt_pkg::FUNC_WEOF,
                       12'($urandom_range(0, tdt_pkg::EOF_WORDS - 1)), rand_action());
        4: write_entry(tdt_pkg::FUNC_WCLASS, 12'(alphabet[$urandom_range(0, 15)]),
                       {16'($urandom), pick_class()});
        5: send_beat($urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7, 8'($urandom),
                     32'($urandom), 12'($urandom), 32'($urandom));
        6: jump_to_state(pick_state());
        default: begin
          if ($urandom_range(0, 1)) jump_to_state(pick_state());
          off = $urandom;
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 15)];
            scan_byte(b, off);
            off += $urandom_range(1, 3);
          end
          if ($urandom_range(0, 3) != 0) end_stream(off);
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = tdt_pkg::FUNC_BYTE;
    in_byte_value  = '0;
    in_byte_offset = '0;
    in_table_index = '0;
    in_table_word  = '0;
    quiet          = 1'b0;
    mismatches     = 0;
    beats_sent     = 0;
    dfa_state      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_eos_from_reset();
    test_action_kinds();
    test_table_edges();
    test_ignored_beats();
    test_random_streams();

    // Let the out side drain, then give stray results a chance to show up.
    quiet = 1'b1;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
